// ===== hw/rtl/ftpd_pkg.sv =====
// ----------------------------------------------------------------------------
// File transfer deframer package
// Shared types and constants for the receive-side packet deframer.
// ----------------------------------------------------------------------------
package ftpd_pkg;

    localparam int FILE_SIZE_BITS_DEFAULT = 32;
    localparam int MODULUS_W              = 9;
    localparam logic [MODULUS_W-1:0] DEFAULT_MODULUS = 9'd100;
    localparam int SIZE_OUT_W             = 32;

    typedef enum logic [1:0] {
        EV_PAYLOAD = 2'd0,
        EV_SIZE    = 2'd1,
        EV_END     = 2'd2
    } event_t;

    typedef struct packed {
        logic [7:0] pkt_byte;
        logic       pkt_last;
        logic       pkt_empty;
    } item_t;

    typedef struct packed {
        event_t                ev;
        logic [7:0]            data_byte;
        logic                  payload_last;
        logic [SIZE_OUT_W-1:0] file_size;
    } result_t;

    typedef struct packed {
        logic    push;
        result_t res;
    } result_push_t;

endpackage

// ===== hw/rtl/file_transfer_packet_deframer_core.sv =====
// ----------------------------------------------------------------------------
// File transfer packet deframer
// Receive side of a packetised file transfer: parses the start packet for the
// file size, checks sequence numbers, passes on payload bytes and reports the end.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  input     in_valid / in_stall    pkt_byte, pkt_last, pkt_empty
//  output    out_valid / out_stall  event_res, data_byte, payload_last, file_size
//  config    cfg_we                 cfg_wdata (sequence modulus)
//
// One byte is taken every cycle while in_stall is low. A taken byte sits in the
// input register; the parser writes its result to the result register, from
// which it can be taken.
// Reset clears all control state and sets the modulus to 100; no clearing pass.
// A stalled result is held, and one further result is caught in a skid entry
// before the input side stalls.
// ----------------------------------------------------------------------------
module file_transfer_packet_deframer_core
#(
    parameter int FILE_SIZE_BITS = ftpd_pkg::FILE_SIZE_BITS_DEFAULT
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     pkt_byte,
    input  logic                           pkt_last,
    input  logic                           pkt_empty,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     event_res,
    output logic [7:0]                     data_byte,
    output logic                           payload_last,
    output logic [ftpd_pkg::SIZE_OUT_W-1:0] file_size,
    input  logic                           cfg_we,
    input  logic [ftpd_pkg::MODULUS_W-1:0] cfg_wdata
);

    logic [ftpd_pkg::MODULUS_W-1:0] modulus_reg;
    ftpd_pkg::item_t                in_item;
    ftpd_pkg::item_t                item;
    logic                           item_valid;
    logic                           consume;
    logic                           out_ready;
    ftpd_pkg::result_push_t         result;
    ftpd_pkg::result_t              out_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= ftpd_pkg::DEFAULT_MODULUS;
        end
        else if (cfg_we)
        begin
            modulus_reg <= cfg_wdata;
        end
    end

    assign in_item.pkt_byte  = pkt_byte;
    assign in_item.pkt_last  = pkt_last;
    assign in_item.pkt_empty = pkt_empty;

    ftpd_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .consume    (consume),
        .item_valid (item_valid),
        .item       (item)
    );

    ftpd_parser
    #(
        .FILE_SIZE_BITS (FILE_SIZE_BITS)
    )
    u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .seq_modulus (modulus_reg),
        .item_valid  (item_valid),
        .item        (item),
        .out_ready   (out_ready),
        .consume     (consume),
        .result      (result)
    );

    ftpd_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .result    (result),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign event_res    = out_res.ev;
    assign data_byte    = out_res.data_byte;
    assign payload_last = out_res.payload_last;
    assign file_size    = out_res.file_size;

    // The skid entry is only ever filled behind a held result.
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        !out_ready |-> out_valid)
        else $error("skid entry full with no result on the output");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        result.push |-> out_ready)
        else $error("result pushed while the skid entry is full");

    a_non_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result.push && result.res.ev != ftpd_pkg::EV_PAYLOAD |->
        result.res.data_byte == 8'd0 && !result.res.payload_last)
        else $error("payload fields set on a non-payload result");

    a_size_only_on_announce: assert property (@(posedge clk) disable iff (!rst_n)
        result.push && result.res.ev != ftpd_pkg::EV_SIZE |->
        result.res.file_size == '0)
        else $error("file size set on a result that does not announce it");

    a_consume_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        consume |-> item_valid)
        else $error("parser consumed an empty input register");

endmodule

// ===== hw/rtl/ftpd_in_stage.sv =====
// ----------------------------------------------------------------------------
// Input stage
// Registers one incoming packet byte and holds it until the parser consumes it.
// ----------------------------------------------------------------------------
module ftpd_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  ftpd_pkg::item_t in_item,
    input  logic            consume,
    output logic            item_valid,
    output ftpd_pkg::item_t item
);

    logic            full_reg;
    logic            full_next;
    ftpd_pkg::item_t item_reg;
    logic            load;

    assign in_stall  = full_reg && !consume;
    assign load      = in_valid && !in_stall;
    assign full_next = (full_reg && !consume) || load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = full_reg;
    assign item       = item_reg;

endmodule

// ===== hw/rtl/ftpd_parser.sv =====
// ----------------------------------------------------------------------------
// Packet parser
// Tracks the transfer phase, byte position, file size and sequence number,
// and produces at most one result for each consumed byte.
// ----------------------------------------------------------------------------
module ftpd_parser
#(
    parameter int FILE_SIZE_BITS = ftpd_pkg::FILE_SIZE_BITS_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [ftpd_pkg::MODULUS_W-1:0]      seq_modulus,
    input  logic                                item_valid,
    input  ftpd_pkg::item_t                     item,
    input  logic                                out_ready,
    output logic                                consume,
    output ftpd_pkg::result_push_t              result
);

    localparam int EXT_W = (FILE_SIZE_BITS > ftpd_pkg::SIZE_OUT_W) ?
                           FILE_SIZE_BITS : ftpd_pkg::SIZE_OUT_W;
    localparam logic [7:0] TYPE_END       = 8'd3;
    localparam logic [8:0] POS_TYPE       = 9'd0;
    localparam logic [8:0] POS_SEQ        = 9'd1;
    localparam logic [8:0] POS_SIZE_LEN   = 9'd2;
    localparam logic [8:0] POS_SIZE_FIRST = 9'd3;
    localparam logic [8:0] PAYLOAD_OFFSET = 9'd4;
    localparam logic [8:0] POS_MAX        = 9'd511;

    typedef enum logic [1:0] {
        PH_START,
        PH_DATA,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        V_UNDECIDED,
        V_ACCEPT,
        V_DROP
    } verdict_t;

    phase_t                    phase_reg,   phase_next;
    logic [8:0]                pos_reg,     pos_next;
    logic [7:0]                len_reg,     len_next;
    logic [FILE_SIZE_BITS-1:0] acc_reg,     acc_next;
    logic [7:0]                seq_reg,     seq_next;
    verdict_t                  verdict_reg, verdict_next;

    logic                      res_valid;
    ftpd_pkg::result_t         res;
    logic [FILE_SIZE_BITS+7:0] acc_shift;
    logic [FILE_SIZE_BITS-1:0] acc_upd;
    logic [EXT_W-1:0]          acc_ext;
    logic [8:0]                seq_inc;
    logic [8:0]                len_ext;

    assign acc_shift = {acc_reg, item.pkt_byte};
    assign seq_inc   = {1'b0, seq_reg} + 9'd1;
    assign len_ext   = {1'b0, len_reg};

    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        acc_next     = acc_reg;
        seq_next     = seq_reg;
        verdict_next = verdict_reg;
        res_valid    = 1'b0;
        acc_upd      = acc_reg;
        acc_ext      = '0;
        res          = '{ev: ftpd_pkg::EV_PAYLOAD, data_byte: 8'd0, payload_last: 1'b0,
                         file_size: '0};

        case (phase_reg)
            PH_DONE:
            begin
            end
            default:
            begin
                if (item.pkt_empty)
                begin
                    pos_next     = '0;
                    verdict_next = V_UNDECIDED;
                    if (phase_reg == PH_START)
                    begin
                        len_next = '0;
                        acc_next = '0;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                        res_valid  = 1'b1;
                        res.ev     = ftpd_pkg::EV_END;
                    end
                end
                else
                begin
                    if (pos_reg != POS_MAX)
                    begin
                        pos_next = pos_reg + 9'd1;
                    end
                    if (phase_reg == PH_START)
                    begin
                        if (pos_reg == POS_SIZE_LEN)
                        begin
                            len_next = item.pkt_byte;
                        end
                        else if (pos_reg >= POS_SIZE_FIRST &&
                                 (pos_reg - POS_SIZE_FIRST) < len_ext)
                        begin
                            acc_upd  = acc_shift[FILE_SIZE_BITS-1:0];
                            acc_next = acc_upd;
                        end
                        if (item.pkt_last)
                        begin
                            acc_ext       = EXT_W'(acc_upd);
                            res_valid     = 1'b1;
                            res.ev        = ftpd_pkg::EV_SIZE;
                            res.file_size = acc_ext[ftpd_pkg::SIZE_OUT_W-1:0];
                            phase_next    = PH_DATA;
                            acc_next      = '0;
                            len_next      = '0;
                            pos_next      = '0;
                            verdict_next  = V_UNDECIDED;
                        end
                    end
                    else
                    begin
                        if (pos_reg == POS_TYPE)
                        begin
                            verdict_next = V_UNDECIDED;
                            if (item.pkt_byte == TYPE_END)
                            begin
                                phase_next = PH_DONE;
                                pos_next   = '0;
                                res_valid  = 1'b1;
                                res.ev     = ftpd_pkg::EV_END;
                            end
                        end
                        else if (pos_reg == POS_SEQ)
                        begin
                            if (item.pkt_byte == seq_reg)
                            begin
                                verdict_next = V_ACCEPT;
                                if (seq_inc >= seq_modulus || seq_inc[8])
                                begin
                                    seq_next = '0;
                                end
                                else
                                begin
                                    seq_next = seq_inc[7:0];
                                end
                            end
                            else
                            begin
                                verdict_next = V_DROP;
                            end
                        end
                        else if (pos_reg >= PAYLOAD_OFFSET && verdict_reg == V_ACCEPT)
                        begin
                            res_valid        = 1'b1;
                            res.ev           = ftpd_pkg::EV_PAYLOAD;
                            res.data_byte    = item.pkt_byte;
                            res.payload_last = item.pkt_last;
                        end
                        if (item.pkt_last && phase_next != PH_DONE)
                        begin
                            pos_next     = '0;
                            verdict_next = V_UNDECIDED;
                        end
                    end
                end
            end
        endcase
    end

    assign consume     = item_valid && (out_ready || !res_valid);
    assign result.push = consume && res_valid;
    assign result.res  = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            pos_reg     <= '0;
            len_reg     <= '0;
            acc_reg     <= '0;
            seq_reg     <= '0;
            verdict_reg <= V_UNDECIDED;
        end
        else if (consume)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            acc_reg     <= acc_next;
            seq_reg     <= seq_next;
            verdict_reg <= verdict_next;
        end
    end

endmodule

// ===== hw/rtl/ftpd_out_stage.sv =====
// ----------------------------------------------------------------------------
// Output stage
// Result register with a skid entry, so that a stalled result does not hold
// up the parser for the cycle in which the stall is seen.
// ----------------------------------------------------------------------------
module ftpd_out_stage
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ftpd_pkg::result_push_t result,
    output logic                   out_ready,
    output logic                   out_valid,
    input  logic                   out_stall,
    output ftpd_pkg::result_t      out_res
);

    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    ftpd_pkg::result_t main_reg;
    ftpd_pkg::result_t skid_reg;
    logic              main_free;

    assign main_free = !main_valid_reg || !out_stall;
    assign out_ready = !skid_valid_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (main_free)
        begin
            main_valid_next = skid_valid_reg || result.push;
            skid_valid_next = 1'b0;
        end
        else if (result.push)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (main_free)
        begin
            main_reg <= skid_valid_reg ? skid_reg : result.res;
        end
        else if (result.push)
        begin
            skid_reg <= result.res;
        end
    end

    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

endmodule
